>>> src/png_chunk_parser_crc_check_unit_macros.svh
// ----------------------------------------------------------------------------
// png chunk parser assertion macros
// concurrent assertion forms used by pcp_parser
// ----------------------------------------------------------------------------
`ifndef PNG_CHUNK_PARSER_CRC_CHECK_UNIT_MACROS_SVH
`define PNG_CHUNK_PARSER_CRC_CHECK_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCP_ASSERT_NOW(name, ck, rn, ante, cons) \
name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("pcp assertion failed");

// antecedent implies consequent in the next cycle
`define PCP_ASSERT_NEXT(name, ck, rn, ante, cons) \
name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("pcp assertion failed");

`endif

>>> src/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// types and constants for the png chunk parser with crc check
// ----------------------------------------------------------------------------
package pcp_pkg;

	localparam logic [2:0] PH_SIG  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CRC  = 3'd4;
	localparam logic [2:0] PH_STOP = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_BAD  = 2'd1;
	localparam logic [1:0] ST_SIG_BAD  = 2'd2;
	localparam logic [1:0] ST_LEN_BAD  = 2'd3;

	localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [31:0] TYPE_IHDR     = 32'h4948_4452;
	localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;

	localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
		8'd13, 8'd10, 8'd26, 8'd10};

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] chunk_id;
		logic [30:0] chunk_length;
		logic        is_header;
		logic        is_end;
		logic [30:0] image_width;
		logic [30:0] image_height;
		logic [7:0]  sample_depth;
		logic [7:0]  colour_kind;
		logic [7:0]  interlace_method;
	} pcp_result_t;

endpackage

>>> src/pcp_crc_byte.sv
// ----------------------------------------------------------------------------
// pcp_crc_byte
// one-byte update of the reflected crc-32
// ----------------------------------------------------------------------------
module pcp_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ (c[0] ? pcp_pkg::CRC_POLY_REFL : 32'd0);
		end
		crc_out = c;
	end

endmodule

>>> src/pcp_parser.sv
// ----------------------------------------------------------------------------
// pcp_parser
// signature check, chunk field parse, crc compare and ihdr capture per word
// ----------------------------------------------------------------------------
`include "png_chunk_parser_crc_check_unit_macros.svh"

module pcp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          data_byte,
	input  logic                start_of_stream,
	output logic                res_valid,
	output pcp_pkg::pcp_result_t res
);

	logic [2:0]  phase_q;
	logic [30:0] cnt_q;
	logic [30:0] length_q;
	logic [31:0] type_q;
	logic [31:0] crc_q;
	logic [31:0] rxcrc_q;
	logic [30:0] width_q;
	logic [30:0] height_q;
	logic [7:0]  depth_q;
	logic [7:0]  colour_q;
	logic [7:0]  interlace_q;

	logic [2:0]  phase_c, phase_n;
	logic [30:0] cnt_c, cnt_n, cnt_inc;
	logic [30:0] length_c, length_n;
	logic [31:0] type_c, type_n;
	logic [31:0] crc_c, crc_n, crc_upd;
	logic [31:0] rxcrc_c, rxcrc_n;
	logic [30:0] width_c, width_n;
	logic [30:0] height_c, height_n;
	logic [7:0]  depth_c, depth_n;
	logic [7:0]  colour_c, colour_n;
	logic [7:0]  interlace_c, interlace_n;
	logic        emit;

	// restart overrides the stored state with its reset value
	assign phase_c     = start_of_stream ? pcp_pkg::PH_SIG : phase_q;
	assign cnt_c       = start_of_stream ? 31'd0 : cnt_q;
	assign length_c    = start_of_stream ? 31'd0 : length_q;
	assign type_c      = start_of_stream ? 32'd0 : type_q;
	assign crc_c       = start_of_stream ? pcp_pkg::CRC_INIT : crc_q;
	assign rxcrc_c     = start_of_stream ? 32'd0 : rxcrc_q;
	assign width_c     = start_of_stream ? 31'd0 : width_q;
	assign height_c    = start_of_stream ? 31'd0 : height_q;
	assign depth_c     = start_of_stream ? 8'd0 : depth_q;
	assign colour_c    = start_of_stream ? 8'd0 : colour_q;
	assign interlace_c = start_of_stream ? 8'd0 : interlace_q;

	assign cnt_inc = cnt_c + 31'd1;

	pcp_crc_byte u_crc (
		.crc_in  (crc_c),
		.data    (data_byte),
		.crc_out (crc_upd)
	);

	always_comb begin
		phase_n     = phase_c;
		cnt_n       = cnt_c;
		length_n    = length_c;
		type_n      = type_c;
		crc_n       = crc_c;
		rxcrc_n     = rxcrc_c;
		width_n     = width_c;
		height_n    = height_c;
		depth_n     = depth_c;
		colour_n    = colour_c;
		interlace_n = interlace_c;
		emit        = 1'b0;

		res.status           = pcp_pkg::ST_OK;
		res.chunk_id         = 32'd0;
		res.chunk_length     = 31'd0;
		res.is_header        = 1'b0;
		res.is_end           = 1'b0;
		res.image_width      = width_c;
		res.image_height     = height_c;
		res.sample_depth     = depth_c;
		res.colour_kind      = colour_c;
		res.interlace_method = interlace_c;

		case (phase_c)
			pcp_pkg::PH_SIG: begin
				if (data_byte != pcp_pkg::SIG_BYTES[cnt_c[2:0]]) begin
					phase_n    = pcp_pkg::PH_STOP;
					emit       = 1'b1;
					res.status = pcp_pkg::ST_SIG_BAD;
				end else if (cnt_c[2:0] == 3'd7) begin
					phase_n  = pcp_pkg::PH_LEN;
					cnt_n    = 31'd0;
					length_n = 31'd0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			pcp_pkg::PH_LEN: begin
				if (cnt_c == 31'd0 && data_byte[7]) begin
					phase_n    = pcp_pkg::PH_STOP;
					emit       = 1'b1;
					res.status = pcp_pkg::ST_LEN_BAD;
				end else begin
					length_n = {length_c[22:0], data_byte};
					cnt_n    = cnt_inc;
					if (cnt_c == 31'd3) begin
						phase_n = pcp_pkg::PH_TYPE;
						cnt_n   = 31'd0;
						type_n  = 32'd0;
						crc_n   = pcp_pkg::CRC_INIT;
					end
				end
			end
			pcp_pkg::PH_TYPE: begin
				type_n = {type_c[23:0], data_byte};
				crc_n  = crc_upd;
				cnt_n  = cnt_inc;
				if (cnt_c == 31'd3) begin
					cnt_n   = 31'd0;
					rxcrc_n = 32'd0;
					phase_n = (length_c == 31'd0) ? pcp_pkg::PH_CRC : pcp_pkg::PH_DATA;
				end
			end
			pcp_pkg::PH_DATA: begin
				crc_n = crc_upd;
				if (type_c == pcp_pkg::TYPE_IHDR) begin
					if (cnt_c < 31'd4) begin
						width_n = {width_c[22:0], data_byte};
					end else if (cnt_c < 31'd8) begin
						height_n = {height_c[22:0], data_byte};
					end else if (cnt_c == 31'd8) begin
						depth_n = data_byte;
					end else if (cnt_c == 31'd9) begin
						colour_n = data_byte;
					end else if (cnt_c == 31'd12) begin
						interlace_n = data_byte;
					end
				end
				cnt_n = cnt_inc;
				if (cnt_inc == length_c) begin
					cnt_n   = 31'd0;
					rxcrc_n = 32'd0;
					phase_n = pcp_pkg::PH_CRC;
				end
			end
			pcp_pkg::PH_CRC: begin
				rxcrc_n = {rxcrc_c[23:0], data_byte};
				cnt_n   = cnt_inc;
				if (cnt_c == 31'd3) begin
					emit             = 1'b1;
					res.status       = ((crc_c ^ pcp_pkg::CRC_INIT) == rxcrc_n) ?
						pcp_pkg::ST_OK : pcp_pkg::ST_CRC_BAD;
					res.chunk_id     = type_c;
					res.chunk_length = length_c;
					res.is_header    = (type_c == pcp_pkg::TYPE_IHDR);
					res.is_end       = (type_c == pcp_pkg::TYPE_IEND);
					cnt_n            = 31'd0;
					crc_n            = pcp_pkg::CRC_INIT;
					if (type_c == pcp_pkg::TYPE_IEND) begin
						phase_n = pcp_pkg::PH_STOP;
					end else begin
						phase_n  = pcp_pkg::PH_LEN;
						length_n = 31'd0;
					end
				end
			end
			default: begin
				phase_n = phase_c;
			end
		endcase
	end

	assign res_valid = step_en & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pcp_pkg::PH_SIG;
			cnt_q       <= 31'd0;
			length_q    <= 31'd0;
			type_q      <= 32'd0;
			crc_q       <= pcp_pkg::CRC_INIT;
			rxcrc_q     <= 32'd0;
			width_q     <= 31'd0;
			height_q    <= 31'd0;
			depth_q     <= 8'd0;
			colour_q    <= 8'd0;
			interlace_q <= 8'd0;
		end else if (step_en) begin
			phase_q     <= phase_n;
			cnt_q       <= cnt_n;
			length_q    <= length_n;
			type_q      <= type_n;
			crc_q       <= crc_n;
			rxcrc_q     <= rxcrc_n;
			width_q     <= width_n;
			height_q    <= height_n;
			depth_q     <= depth_n;
			colour_q    <= colour_n;
			interlace_q <= interlace_n;
		end
	end

	`PCP_ASSERT_NOW(a_stop_silent, clk, arst_n,
		phase_q == pcp_pkg::PH_STOP && !start_of_stream, !res_valid)
	`PCP_ASSERT_NOW(a_sig_count, clk, arst_n, phase_q == pcp_pkg::PH_SIG, cnt_q < 31'd8)
	`PCP_ASSERT_NOW(a_field_count, clk, arst_n,
		phase_q == pcp_pkg::PH_LEN || phase_q == pcp_pkg::PH_TYPE ||
		phase_q == pcp_pkg::PH_CRC, cnt_q < 31'd4)
	`PCP_ASSERT_NEXT(a_error_stops, clk, arst_n,
		res_valid && (res.status == pcp_pkg::ST_SIG_BAD || res.status == pcp_pkg::ST_LEN_BAD),
		phase_q == pcp_pkg::PH_STOP)

endmodule

>>> src/pcp_out_reg.sv
// ----------------------------------------------------------------------------
// pcp_out_reg
// result register with valid and ready toward the receiver
// ----------------------------------------------------------------------------
module pcp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pcp_pkg::pcp_result_t res,
	output logic                free,
	output logic                valid,
	input  logic                ready,
	output pcp_pkg::pcp_result_t res_q
);

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

>>> src/png_chunk_parser_crc_check_unit.sv
// ----------------------------------------------------------------------------
// png_chunk_parser_crc_check_unit
// byte-stream png signature check, chunk parse and crc-32 verify
// ----------------------------------------------------------------------------
// input channel: byte_valid / byte_ready carry one word per handshake, a
// file byte with start_of_stream marking the first signature byte of a file
// output channel: result_valid / result_ready carry one word per finished
// chunk, or one on a bad signature or an oversized length, with the ihdr
// fields captured so far
// path: a byte enters the input register, is parsed once the result register
// is free, and any result it causes is loaded into the result register at
// the end of the cycle in which it is parsed
// throughput: one byte per cycle while the result register is free; chunk state
// and crc byte updates are combinational between input and result registers
// reset: parser returns to the signature phase, crc preset to all ones,
// captured ihdr fields zero, both registers empty
// stall: while result_ready is low and a result is held, the input
// register still takes one more byte, then byte_ready drops
// after iend or an error bytes are taken and dropped until start_of_stream
// ----------------------------------------------------------------------------
module png_chunk_parser_crc_check_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_stream,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [31:0] chunk_id,
	output logic [30:0] chunk_length,
	output logic        is_header,
	output logic        is_end,
	output logic [30:0] image_width,
	output logic [30:0] image_height,
	output logic [7:0]  sample_depth,
	output logic [7:0]  colour_kind,
	output logic [7:0]  interlace_method
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 sos_s1;
	logic                 advance;
	logic                 step_en;
	logic                 res_valid;
	pcp_pkg::pcp_result_t res;
	pcp_pkg::pcp_result_t res_q;

	assign byte_ready = !valid_s1 || advance;
	assign step_en    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= data_byte;
			sos_s1  <= start_of_stream;
		end
	end

	pcp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step_en),
		.data_byte       (data_s1),
		.start_of_stream (sos_s1),
		.res_valid       (res_valid),
		.res             (res)
	);

	pcp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.free   (advance),
		.valid  (result_valid),
		.ready  (result_ready),
		.res_q  (res_q)
	);

	assign status           = res_q.status;
	assign chunk_id         = res_q.chunk_id;
	assign chunk_length     = res_q.chunk_length;
	assign is_header        = res_q.is_header;
	assign is_end           = res_q.is_end;
	assign image_width      = res_q.image_width;
	assign image_height     = res_q.image_height;
	assign sample_depth     = res_q.sample_depth;
	assign colour_kind      = res_q.colour_kind;
	assign interlace_method = res_q.interlace_method;

endmodule
